>>> design/eta_pkg.sv
// package for the environment threshold alarm
// item codes, register indexes, field types and reset values; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package eta_pkg;

    // alarm codes
    localparam logic [1:0] ALM_CLEAR = 2'd0;
    localparam logic [1:0] ALM_LOW   = 2'd1;
    localparam logic [1:0] ALM_HIGH  = 2'd2;

    // device codes
    localparam logic [2:0] DEV_LED_TEMP  = 3'd0;
    localparam logic [2:0] DEV_LED_HUM   = 3'd1;
    localparam logic [2:0] DEV_LED_LIGHT = 3'd2;
    localparam logic [2:0] DEV_FAN       = 3'd3;
    localparam logic [2:0] DEV_BEEPER    = 3'd4;

    // action codes
    localparam logic [1:0] ACT_OFF  = 2'd0;
    localparam logic [1:0] ACT_ON   = 2'd1;
    localparam logic [1:0] ACT_FAN3 = 2'd2;

    // item kinds
    localparam logic KIND_CMD    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] FAN_FULL = 2'd3;

    // register indexes (byte address 4 * index)
    localparam logic [2:0] REG_TEMP_MAX  = 3'd0;
    localparam logic [2:0] REG_TEMP_MIN  = 3'd1;
    localparam logic [2:0] REG_HUM_MAX   = 3'd2;
    localparam logic [2:0] REG_HUM_MIN   = 3'd3;
    localparam logic [2:0] REG_LIGHT_MAX = 3'd4;
    localparam logic [2:0] REG_LIGHT_MIN = 3'd5;

    localparam logic signed [14:0] TEMP_MAX_RST  = 15'sd3500;
    localparam logic signed [14:0] TEMP_MIN_RST  = 15'sd500;
    localparam logic [13:0]        HUM_MAX_RST   = 14'd8000;
    localparam logic [13:0]        HUM_MIN_RST   = 14'd2000;
    localparam logic [15:0]        LIGHT_MAX_RST = 16'd60000;
    localparam logic [15:0]        LIGHT_MIN_RST = 16'd100;

    // most commands one reading can emit, plus the status item
    localparam int MAX_CMDS  = 8;
    localparam int MAX_ITEMS = MAX_CMDS + 1;

    typedef struct packed {
        logic [2:0] device;
        logic [1:0] action;
    } cmd_t;

    typedef struct packed {
        logic [3:0]                cnt;
        cmd_t [MAX_CMDS-1:0]       cmds;
    } cmd_list_t;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic [15:0] data;
    } out_item_t;

    function automatic cmd_list_t add_cmd(cmd_list_t l, logic [2:0] dev, logic [1:0] act);
        cmd_list_t r;
        r = l;
        if (l.cnt < 4'(MAX_CMDS)) begin
            r.cmds[l.cnt[2:0]] = '{device: dev, action: act};
            r.cnt = l.cnt + 4'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/environment_threshold_alarm.sv
// environment threshold alarm: top level with apb register file and item logic
// depends on eta_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
// s_axis carries one reading per item: tdata holds temperature, humidity and
// illumination. m_axis carries the items one reading causes: zero to eight
// device commands and then one status item, which alone has tlast set; tuser
// tells a status item (1) from a device command (0).
// The user must write the limits through the apb port only while the block is idle; the block does not enforce it.
// Flow: a reading is taken into the input register, evaluated there and loaded
// into the output buffer once the buffer is free; its items are then offered
// from entry 0 of the buffer. Items leave one per cycle from the output buffer
// while the receiver takes them; the next reading is accepted into the input
// register while the buffer still drains and is loaded as the last item is taken.
// When the receiver stalls, the buffer holds and the input register fills,
// then s_axis_tready falls until the buffer has drained.
// Reset (aresetn low, synchronous) clears all alarms, beeper, fan and light
// LED, empties both stages and restores the default limits.

module environment_threshold_alarm
    import eta_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // temp_reading [14:0], hum_reading [28:15], light_reading [44:29]
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // device [2:0], action [4:3], fan_level [6:5], light_led_on [7],
    // temp_alarm [9:8], hum_alarm [11:10], light_alarm [13:12], beeper_on [14]
    output logic [15:0]      m_axis_tdata,
    // item_kind [0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration
    logic signed [14:0] temp_max_reg, temp_min_reg;
    logic [13:0]        hum_max_reg, hum_min_reg;
    logic [15:0]        light_max_reg, light_min_reg;
    logic               cfg_wr;

    // input stage
    logic               in_valid_reg;
    logic signed [14:0] in_temp_reg;
    logic [13:0]        in_hum_reg;
    logic [15:0]        in_light_reg;

    // alarm state
    logic [1:0] temp_alarm_reg, hum_alarm_reg, light_alarm_reg;
    logic       beeper_reg;
    logic [1:0] fan_reg;
    logic       light_led_reg;

    logic [1:0] temp_alarm_next, hum_alarm_next, light_alarm_next;
    logic       beeper_next;
    logic [1:0] fan_next;
    logic       light_led_next;

    // output buffer, entry 0 is on the port
    out_item_t  buf_reg  [MAX_ITEMS];
    out_item_t  buf_next [MAX_ITEMS];
    logic [3:0] cnt_reg;

    logic       take;
    logic       load;
    cmd_list_t  list;
    logic [2:0] over_v, under_v, inside_v;

    // ---------------- apb ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_max_reg  <= TEMP_MAX_RST;
            temp_min_reg  <= TEMP_MIN_RST;
            hum_max_reg   <= HUM_MAX_RST;
            hum_min_reg   <= HUM_MIN_RST;
            light_max_reg <= LIGHT_MAX_RST;
            light_min_reg <= LIGHT_MIN_RST;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_TEMP_MAX:  temp_max_reg  <= pwdata[14:0];
                REG_TEMP_MIN:  temp_min_reg  <= pwdata[14:0];
                REG_HUM_MAX:   hum_max_reg   <= pwdata[13:0];
                REG_HUM_MIN:   hum_min_reg   <= pwdata[13:0];
                REG_LIGHT_MAX: light_max_reg <= pwdata[15:0];
                REG_LIGHT_MIN: light_min_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_TEMP_MAX:  prdata = 32'(temp_max_reg);
            REG_TEMP_MIN:  prdata = 32'(temp_min_reg);
            REG_HUM_MAX:   prdata = {18'd0, hum_max_reg};
            REG_HUM_MIN:   prdata = {18'd0, hum_min_reg};
            REG_LIGHT_MAX: prdata = {16'd0, light_max_reg};
            REG_LIGHT_MIN: prdata = {16'd0, light_min_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign m_axis_tvalid = (cnt_reg != 4'd0);
    assign take          = m_axis_tvalid & m_axis_tready;
    // buffer is free now or frees with this take
    assign load          = in_valid_reg & ((cnt_reg == 4'd0) | ((cnt_reg == 4'd1) & take));
    assign s_axis_tready = ~in_valid_reg | load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready & s_axis_tvalid) begin
            in_temp_reg  <= s_axis_tdata[14:0];
            in_hum_reg   <= s_axis_tdata[28:15];
            in_light_reg <= s_axis_tdata[44:29];
        end
    end

    // ---------------- evaluation ----------------
    always_comb begin
        over_v[0]   = in_temp_reg > temp_max_reg;
        under_v[0]  = in_temp_reg < temp_min_reg;
        inside_v[0] = (in_temp_reg < temp_max_reg) && (in_temp_reg > temp_min_reg);
        over_v[1]   = in_hum_reg > hum_max_reg;
        under_v[1]  = in_hum_reg < hum_min_reg;
        inside_v[1] = (in_hum_reg < hum_max_reg) && (in_hum_reg > hum_min_reg);
        over_v[2]   = in_light_reg > light_max_reg;
        under_v[2]  = in_light_reg < light_min_reg;
        inside_v[2] = (in_light_reg < light_max_reg) && (in_light_reg > light_min_reg);
    end

    always_comb begin
        logic [1:0] alm [3];
        logic [2:0] led_dev;
        alm[0]         = temp_alarm_reg;
        alm[1]         = hum_alarm_reg;
        alm[2]         = light_alarm_reg;
        beeper_next    = beeper_reg;
        fan_next       = fan_reg;
        light_led_next = light_led_reg;
        list           = '0;

        // temperature then humidity, both drive the fan
        for (int c = 0; c < 2; c++) begin
            led_dev = (c == 0) ? DEV_LED_TEMP : DEV_LED_HUM;
            if (alm[c] == ALM_CLEAR) begin
                if (over_v[c] || under_v[c]) begin
                    list = add_cmd(list, led_dev, ACT_ON);
                    if (over_v[c]) begin
                        list     = add_cmd(list, DEV_FAN, ACT_FAN3);
                        fan_next = FAN_FULL;
                        alm[c]   = ALM_HIGH;
                    end else begin
                        list     = add_cmd(list, DEV_FAN, ACT_OFF);
                        fan_next = 2'd0;
                        alm[c]   = ALM_LOW;
                    end
                    if (!beeper_next) begin
                        beeper_next = 1'b1;
                        list = add_cmd(list, led_dev, ACT_ON);
                        list = add_cmd(list, DEV_BEEPER, ACT_ON);
                    end
                end
            end else if (inside_v[c]) begin
                list     = add_cmd(list, led_dev, ACT_OFF);
                list     = add_cmd(list, DEV_FAN, ACT_OFF);
                fan_next = 2'd0;
                alm[c]   = ALM_CLEAR;
                if (alm[0] == ALM_CLEAR && alm[1] == ALM_CLEAR && alm[2] == ALM_CLEAR) begin
                    beeper_next = 1'b0;
                    list = add_cmd(list, DEV_BEEPER, ACT_OFF);
                end
            end
        end

        // illumination drives the light led flag
        if (alm[2] == ALM_CLEAR) begin
            if (over_v[2] || under_v[2]) begin
                list           = add_cmd(list, DEV_LED_LIGHT, ACT_ON);
                light_led_next = ~over_v[2];
                alm[2]         = over_v[2] ? ALM_HIGH : ALM_LOW;
                if (!beeper_next) begin
                    beeper_next = 1'b1;
                    list = add_cmd(list, DEV_LED_LIGHT, ACT_ON);
                    list = add_cmd(list, DEV_BEEPER, ACT_ON);
                end
            end
        end else if (inside_v[2]) begin
            list           = add_cmd(list, DEV_LED_LIGHT, ACT_OFF);
            light_led_next = 1'b0;
            alm[2]         = ALM_CLEAR;
            if (alm[0] == ALM_CLEAR && alm[1] == ALM_CLEAR) begin
                beeper_next = 1'b0;
                list = add_cmd(list, DEV_BEEPER, ACT_OFF);
            end
        end

        temp_alarm_next  = alm[0];
        hum_alarm_next   = alm[1];
        light_alarm_next = alm[2];
    end

    // command items first, then the status item
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (4'(i) < list.cnt) begin
                buf_next[i].kind = KIND_CMD;
                buf_next[i].last = 1'b0;
                buf_next[i].data = {11'd0, list.cmds[i % MAX_CMDS].action,
                                    list.cmds[i % MAX_CMDS].device};
            end else if (4'(i) == list.cnt) begin
                buf_next[i].kind = KIND_STATUS;
                buf_next[i].last = 1'b1;
                buf_next[i].data = {1'b0, beeper_next, light_alarm_next, hum_alarm_next,
                                    temp_alarm_next, light_led_next, fan_next,
                                    ACT_OFF, DEV_LED_TEMP};
            end else begin
                buf_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_alarm_reg  <= ALM_CLEAR;
            hum_alarm_reg   <= ALM_CLEAR;
            light_alarm_reg <= ALM_CLEAR;
            beeper_reg      <= 1'b0;
            fan_reg         <= 2'd0;
            light_led_reg   <= 1'b0;
            cnt_reg         <= 4'd0;
        end else begin
            if (load) begin
                temp_alarm_reg  <= temp_alarm_next;
                hum_alarm_reg   <= hum_alarm_next;
                light_alarm_reg <= light_alarm_next;
                beeper_reg      <= beeper_next;
                fan_reg         <= fan_next;
                light_led_reg   <= light_led_next;
                cnt_reg         <= list.cnt + 4'd1;
            end else if (take) begin
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < MAX_ITEMS; i++) begin
                buf_reg[i] <= buf_next[i];
            end
        end else if (take) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    assign m_axis_tdata = buf_reg[0].data;
    assign m_axis_tuser = buf_reg[0].kind;
    assign m_axis_tlast = buf_reg[0].last;

    // ---------------- checks ----------------
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_STATUS)
        else $error("last item is not a status item");

    a_beeper_tracks_alarms: assert property (@(posedge aclk) disable iff (!aresetn)
        beeper_reg == ((temp_alarm_reg != ALM_CLEAR) || (hum_alarm_reg != ALM_CLEAR)
                       || (light_alarm_reg != ALM_CLEAR)))
        else $error("beeper disagrees with alarm state");

    a_fan_level: assert property (@(posedge aclk) disable iff (!aresetn)
        fan_reg == 2'd0 || fan_reg == FAN_FULL)
        else $error("fan level neither off nor full");

    a_buffer_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 4'(MAX_ITEMS))
        else $error("output buffer count out of range");

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking bench for environment_threshold_alarm: directed and random readings
// predicts every command and status item; depends on eta_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;
    import eta_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // channel indexes into the alarm array
    localparam int CH_TEMP  = 0;
    localparam int CH_HUM   = 1;
    localparam int CH_LIGHT = 2;

    // addresses past the last register
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [2:0] device;
        logic [1:0] action;
        logic [1:0] fan;
        logic       led;
        logic [1:0] t_alm;
        logic [1:0] h_alm;
        logic [1:0] l_alm;
        logic       beep;
        logic       is_last;
    } alarm_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // limits as the block should hold them
    logic signed [14:0] temp_max_q  = TEMP_MAX_RST;
    logic signed [14:0] temp_min_q  = TEMP_MIN_RST;
    logic [13:0]        hum_max_q   = HUM_MAX_RST;
    logic [13:0]        hum_min_q   = HUM_MIN_RST;
    logic [15:0]        light_max_q = LIGHT_MAX_RST;
    logic [15:0]        light_min_q = LIGHT_MIN_RST;

    logic [1:0] alarm_st [3] = '{ALM_CLEAR, ALM_CLEAR, ALM_CLEAR};
    logic       beep_st = 1'b0;
    logic [1:0] fan_st = 2'd0;
    logic       led_st = 1'b0;

    alarm_item_t expected_items [$];
    int          cmds_in_step;
    int          mismatch_count = 0;
    int          src_idle_pct = 8;
    int          sink_stall_pct = 67;
    int          cycle_count = 0;

    environment_threshold_alarm i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    function automatic void push_cmd(logic [2:0] dev, logic [1:0] act);
        alarm_item_t it;
        it = '0;
        it.kind = KIND_CMD;
        it.device = dev;
        it.action = act;
        if (cmds_in_step < MAX_CMDS) begin
            expected_items.push_back(it);
            cmds_in_step++;
        end
    endfunction

    function automatic void beep_on_raise(logic [2:0] led);
        if (!beep_st) begin
            beep_st = 1'b1;
            push_cmd(led, ACT_ON);
            push_cmd(DEV_BEEPER, ACT_ON);
        end
    endfunction

    function automatic void beep_off_if_quiet();
        if (alarm_st[CH_TEMP] == ALM_CLEAR && alarm_st[CH_HUM] == ALM_CLEAR &&
            alarm_st[CH_LIGHT] == ALM_CLEAR) begin
            beep_st = 1'b0;
            push_cmd(DEV_BEEPER, ACT_OFF);
        end
    endfunction

    // temperature and humidity both drive the fan
    function automatic void fan_channel(int ch, logic over, logic under, logic between);
        logic [2:0] led;
        led = (ch == CH_TEMP) ? DEV_LED_TEMP : DEV_LED_HUM;
        if (alarm_st[ch] == ALM_CLEAR) begin
            if (over) begin
                push_cmd(led, ACT_ON);
                push_cmd(DEV_FAN, ACT_FAN3);
                fan_st = FAN_FULL;
                alarm_st[ch] = ALM_HIGH;
                beep_on_raise(led);
            end else if (under) begin
                push_cmd(led, ACT_ON);
                push_cmd(DEV_FAN, ACT_OFF);
                fan_st = 2'd0;
                alarm_st[ch] = ALM_LOW;
                beep_on_raise(led);
            end
        end else if (between) begin
            push_cmd(led, ACT_OFF);
            push_cmd(DEV_FAN, ACT_OFF);
            fan_st = 2'd0;
            alarm_st[ch] = ALM_CLEAR;
            beep_off_if_quiet();
        end
    endfunction

    function automatic void predict_reading(logic [47:0] d);
        logic signed [14:0] t;
        logic [13:0]        h;
        logic [15:0]        l;
        alarm_item_t        st;
        t = d[14:0];
        h = d[28:15];
        l = d[44:29];
        cmds_in_step = 0;
        fan_channel(CH_TEMP, t > temp_max_q, t < temp_min_q,
                    t < temp_max_q && t > temp_min_q);
        fan_channel(CH_HUM, h > hum_max_q, h < hum_min_q,
                    h < hum_max_q && h > hum_min_q);
        if (alarm_st[CH_LIGHT] == ALM_CLEAR) begin
            if (l > light_max_q) begin
                push_cmd(DEV_LED_LIGHT, ACT_ON);
                led_st = 1'b0;
                alarm_st[CH_LIGHT] = ALM_HIGH;
                beep_on_raise(DEV_LED_LIGHT);
            end else if (l < light_min_q) begin
                push_cmd(DEV_LED_LIGHT, ACT_ON);
                led_st = 1'b1;
                alarm_st[CH_LIGHT] = ALM_LOW;
                beep_on_raise(DEV_LED_LIGHT);
            end
        end else if (l < light_max_q && l > light_min_q) begin
            push_cmd(DEV_LED_LIGHT, ACT_OFF);
            led_st = 1'b0;
            alarm_st[CH_LIGHT] = ALM_CLEAR;
            beep_off_if_quiet();
        end
        st = '0;
        st.kind = KIND_STATUS;
        st.fan = fan_st;
        st.led = led_st;
        st.t_alm = alarm_st[CH_TEMP];
        st.h_alm = alarm_st[CH_HUM];
        st.l_alm = alarm_st[CH_LIGHT];
        st.beep = beep_st;
        st.is_last = 1'b1;
        expected_items.push_back(st);
    endfunction

    function automatic string item_text(alarm_item_t it);
        return {$sformatf("kind %0d dev %0d act %0d fan %0d led %0d ",
                          it.kind, it.device, it.action, it.fan, it.led),
                $sformatf("alarms %0d/%0d/%0d beep %0d last %0d",
                          it.t_alm, it.h_alm, it.l_alm, it.beep, it.is_last)};
    endfunction

    // register writes, accepted readings and emitted items, all seen at the edge
    always @(posedge aclk) begin
        alarm_item_t got;
        alarm_item_t want;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_TEMP_MAX:  temp_max_q = pwdata[14:0];
                    REG_TEMP_MIN:  temp_min_q = pwdata[14:0];
                    REG_HUM_MAX:   hum_max_q = pwdata[13:0];
                    REG_HUM_MIN:   hum_min_q = pwdata[13:0];
                    REG_LIGHT_MAX: light_max_q = pwdata[15:0];
                    REG_LIGHT_MIN: light_min_q = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_reading(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.device = m_axis_tdata[2:0];
                got.action = m_axis_tdata[4:3];
                got.fan = m_axis_tdata[6:5];
                got.led = m_axis_tdata[7];
                got.t_alm = m_axis_tdata[9:8];
                got.h_alm = m_axis_tdata[11:10];
                got.l_alm = m_axis_tdata[13:12];
                got.beep = m_axis_tdata[14];
                got.is_last = m_axis_tlast;
                if (expected_items.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected item: %s", item_text(got));
                    mismatch_count++;
                end else begin
                    want = expected_items.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("item mismatch: expected %s, got %s",
                                     item_text(want), item_text(got));
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_reading(logic [14:0] temp, logic [13:0] hum, logic [15:0] light);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, light, hum, temp};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // hold off the sender until every predicted item has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_items.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // reading placed around a pair of limits: outside, on a limit, between or anywhere
    function automatic int pick_reading(int lo, int hi, bit between_only);
        int span;
        int sel;
        span = hi - lo;
        sel = between_only ? 2 : int'($urandom_range(9));
        case (sel)
            0:       return lo - 1 - int'($urandom_range(40));
            1:       return lo;
            2, 3, 4: return (span > 1) ? lo + 1 + int'($urandom_range(span - 2)) : lo + 1;
            5:       return hi;
            6:       return hi + 1 + int'($urandom_range(40));
            default: return int'($urandom);
        endcase
    endfunction

    task automatic apply_random_limits();
        logic [2:0] max_reg [3];
        logic [2:0] min_reg [3];
        int         a;
        int         b;
        int         tmp;
        logic [31:0] mask;
        max_reg = '{REG_TEMP_MAX, REG_HUM_MAX, REG_LIGHT_MAX};
        min_reg = '{REG_TEMP_MIN, REG_HUM_MIN, REG_LIGHT_MIN};
        for (int ch = 0; ch < 3; ch++) begin
            case (ch)
                CH_TEMP: begin
                    a = int'($urandom_range(25599)) - 12800;
                    b = int'($urandom_range(25599)) - 12800;
                    mask = 32'h7FFF;
                end
                CH_HUM: begin
                    a = int'($urandom_range(12799));
                    b = int'($urandom_range(12799));
                    mask = 32'h3FFF;
                end
                default: begin
                    a = int'($urandom_range(65535));
                    b = int'($urandom_range(65535));
                    mask = 32'hFFFF;
                end
            endcase
            // usually leave the limits crossed, now and then keep max above min
            if ((a < b) == ($urandom_range(5) == 0)) begin
                tmp = a;
                a = b;
                b = tmp;
            end
            write_reg(max_reg[ch], 32'(a) & mask);
            write_reg(min_reg[ch], 32'(b) & mask);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_default_limits();
        send_reading(2000, 5000, 1000);
        send_reading(3600, 5000, 1000);     // temperature high, beeper on
        send_reading(3500, 9000, 1000);     // on the limit, humidity high
        send_reading(2000, 5000, 50);       // temperature and humidity clear, light low
        send_reading(2000, 5000, 100);
        send_reading(2000, 5000, 1000);     // last clear turns beeper off
        send_reading(400, 1000, 65535);     // every channel raises at once
        send_reading(500, 2000, 60000);
        send_reading(2000, 5000, 1000);
        send_reading(3500, 8000, 60000);
        send_reading(500, 2000, 100);
        send_reading(15'h4000, 0, 0);
        send_reading(15'h3FFF, 14'h3FFF, 16'hFFFF);
        send_reading(2000, 5000, 1000);
        send_reading(15'h3FFF, 14'h3FFF, 16'hFFFF);
    endtask

    task automatic test_extreme_and_crossed_limits();
        wait_drained();
        write_reg(REG_TEMP_MAX, 32'h3FFF);
        write_reg(REG_TEMP_MIN, 32'h4000);
        write_reg(REG_HUM_MAX, 32'h3FFF);
        write_reg(REG_HUM_MIN, 32'h0);
        write_reg(REG_LIGHT_MAX, 32'hFFFF);
        write_reg(REG_LIGHT_MIN, 32'h0);
        write_reg(REG_SPARE_LO, 32'h0);
        write_reg(REG_SPARE_HI, 32'h1);
        send_reading(2000, 5000, 1000);
        send_reading(15'h4000, 0, 0);
        send_reading(15'h3FFF, 14'h3FFF, 16'hFFFF);
        // min above max: everything raises, nothing clears
        wait_drained();
        write_reg(REG_TEMP_MAX, 32'h4000);
        write_reg(REG_TEMP_MIN, 32'h3FFF);
        write_reg(REG_HUM_MAX, 32'h0);
        write_reg(REG_HUM_MIN, 32'h3FFF);
        write_reg(REG_LIGHT_MAX, 32'h0);
        write_reg(REG_LIGHT_MIN, 32'hFFFF);
        send_reading(0, 5000, 30000);
        send_reading(0, 5000, 30000);
        // min equal to max
        wait_drained();
        write_reg(REG_TEMP_MAX, 32'd1000);
        write_reg(REG_TEMP_MIN, 32'd1000);
        write_reg(REG_HUM_MAX, 32'd3000);
        write_reg(REG_HUM_MIN, 32'd3000);
        write_reg(REG_LIGHT_MAX, 32'd500);
        write_reg(REG_LIGHT_MIN, 32'd500);
        send_reading(1000, 3000, 500);
        send_reading(1001, 2999, 499);
    endtask

    task automatic test_random_readings(int src_pct, int sink_pct, int count);
        bit inside_all;
        int t;
        int h;
        int l;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 24 == 0) begin
                wait_drained();
                apply_random_limits();
            end
            // in ordered windows a reading inside all clears alarms and the beeper
            inside_all = ($urandom_range(4) == 0);
            t = pick_reading(int'(temp_min_q), int'(temp_max_q), inside_all);
            h = pick_reading(int'(hum_min_q), int'(hum_max_q), inside_all);
            l = pick_reading(int'(light_min_q), int'(light_max_q), inside_all);
            send_reading(t[14:0], h[13:0], l[15:0]);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_limits();
        test_extreme_and_crossed_limits();
        test_random_readings(8, 67, 62);
        test_random_readings(67, 8, 62);
        test_random_readings(0, 0, 62);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_items.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
